FILE: src/hsva_pkg.sv
`default_nettype none
package hsva_pkg;

    localparam int PixelWidth = 8;
    localparam int HueWidth = 9;
    localparam int PctWidth = 8;
    localparam int CfgIndexWidth = 2;

    localparam logic [CfgIndexWidth-1:0] CFG_HUE_SHIFT = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_SAT_SHIFT = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_VAL_SHIFT = 2'd2;

    // Adjusted HSV triple handed from the forward half to the back half.
    typedef struct packed {
        logic [8:0] hue;   // 0..359
        logic [6:0] sat;   // 0..100
        logic [6:0] val;   // 0..100
    } hsv_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // floor(x / 255) for x < 25600, via reciprocal multiply.
    function automatic logic [6:0] div255(input logic [14:0] x);
        logic [31:0] prod;
        begin
            prod = 32'(x) * 32'd32897;  // ceil(2^23 / 255)
            div255 = prod[29:23];
        end
    endfunction

endpackage
`default_nettype wire

FILE: src/hsv_adjust_pixel_unit.sv
`default_nettype none
// Per-pixel hue/saturation/value adjust. One pixel per clock while the result is not
// stalled. Pipeline: one input stage, seven divider stages (one quotient bit per stage),
// the adjust stage and the four-stage back conversion. The whole pipeline advances
// when the output slot is free or empty; a stalled result holds everything in place.
module hsv_adjust_pixel_unit
    import hsva_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // in_red, in_green, in_blue
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // out_red, out_green, out_blue
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_data
);
    localparam int Depth = 13;
    logic signed [8:0] hue_reg;
    logic signed [7:0] sat_reg, val_reg;
    logic [Depth-1:0] vld_reg;
    logic en;
    rgb_t pix, res;
    hsv_t hsv;

    assign en = !vld_reg[Depth-1] || m_tready;
    assign s_tready = en;
    assign cfg_ready = 1'b1;
    assign m_tvalid = vld_reg[Depth-1];
    assign pix = '{red: s_tdata[7:0], green: s_tdata[15:8], blue: s_tdata[23:16]};
    assign m_tdata = {res.blue, res.green, res.red};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            hue_reg <= '0;
            sat_reg <= '0;
            val_reg <= '0;
        end else begin
            if (en) vld_reg <= {vld_reg[Depth-2:0], s_tvalid};
            if (cfg_valid) begin
                if (cfg_index == CFG_HUE_SHIFT) hue_reg <= cfg_data;
                if (cfg_index == CFG_SAT_SHIFT) sat_reg <= cfg_data[7:0];
                if (cfg_index == CFG_VAL_SHIFT) val_reg <= cfg_data[7:0];
            end
        end
    end

    hsva_forward u_fwd (
        .aclk, .en, .pix, .hue_shift(hue_reg), .sat_shift(sat_reg),
        .val_shift(val_reg), .hsv_reg(hsv)
    );
    hsva_back u_back (.aclk, .en, .hsv, .rgb_reg(res));

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready) else $error("stalled while output empty");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg)) else $error("pipeline moved under stall");
endmodule
`default_nettype wire

FILE: src/hsva_divider.sv
`default_nettype none
// Pipelined restoring divider: quotient of num / den, QW bits, one bit per stage.
// Carries a side payload along.
module hsva_divider
    import hsva_pkg::*;
#(
    parameter int NW = 16,
    parameter int DW = 8,
    parameter int QW = 8,
    parameter int PW = 8
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic [PW-1:0] side_in,
    output logic      [QW-1:0] quo,
    output logic      [PW-1:0] side_out
);
    logic [NW-1:0] rem_reg  [QW+1];
    logic [DW-1:0] den_reg  [QW+1];
    logic [QW-1:0] q_reg    [QW+1];
    logic [PW-1:0] side_reg [QW+1];

    always_comb begin
        rem_reg[0]  = num;
        den_reg[0]  = den;
        q_reg[0]    = '0;
        side_reg[0] = side_in;
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int Sh = QW - 1 - k;
        logic [NW+QW-1:0] trial;
        logic             take;
        always_comb begin
            trial = (NW+QW)'(den_reg[k]) << Sh;
            take  = (NW+QW)'(rem_reg[k]) >= trial;
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= take ? NW'((NW+QW)'(rem_reg[k]) - trial) : rem_reg[k];
                den_reg[k+1]  <= den_reg[k];
                q_reg[k+1]    <= q_reg[k] | (QW'(take) << Sh);
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign quo      = q_reg[QW];
    assign side_out = side_reg[QW];
endmodule
`default_nettype wire

FILE: src/hsva_forward.sv
`default_nettype none
// RGB to adjusted HSV. Stage 0 finds max/min, dividers run, final stage adjusts.
module hsva_forward
    import hsva_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire rgb_t              pix,
    input  wire logic signed [8:0] hue_shift,
    input  wire logic signed [7:0] sat_shift,
    input  wire logic signed [7:0] val_shift,
    output hsv_t                   hsv_reg
);
    localparam int Lat = 9;  // stage 0, the divider stages and the adjust stage
    logic [7:0] mx, mn, dl;
    logic [1:0] sel;
    logic [7:0] hnum;
    logic       hneg;
    always_comb begin
        mx = pix.red;
        mn = pix.red;
        if (pix.green > mx) mx = pix.green;
        if (pix.blue > mx) mx = pix.blue;
        if (pix.green < mn) mn = pix.green;
        if (pix.blue < mn) mn = pix.blue;
        dl = mx - mn;
        hneg = 1'b0;
        if (mx == pix.red) begin
            sel = 2'd0;
            hneg = pix.green < pix.blue;
            hnum = hneg ? pix.blue - pix.green : pix.green - pix.blue;
        end else if (mx == pix.green) begin
            sel = 2'd1;
            hneg = pix.blue < pix.red;
            hnum = hneg ? pix.red - pix.blue : pix.blue - pix.red;
        end else begin
            sel = 2'd2;
            hneg = pix.red < pix.green;
            hnum = hneg ? pix.green - pix.red : pix.red - pix.green;
        end
    end

    logic [13:0] hn_reg;
    logic [14:0] sn_reg;
    logic [7:0]  dl_reg, mx_reg;
    logic [1:0]  sel_reg;
    logic        neg_reg;
    logic [6:0]  v_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            // green and blue sectors floor the whole sum: round the negative
            // offset's magnitude up so the quotient comes out floored
            hn_reg  <= 14'(hnum) * 14'd60 +
                       ((hneg && sel != 2'd0) ? 14'(dl) - 14'd1 : 14'd0);
            sn_reg  <= 15'(dl) * 15'd100;
            dl_reg  <= (dl == 8'd0) ? 8'd1 : dl;
            mx_reg  <= (mx == 8'd0) ? 8'd1 : mx;
            sel_reg <= (dl == 8'd0) ? 2'd0 : sel;
            neg_reg <= hneg;
            v_reg   <= div255(15'(mx) * 15'd100);
        end
    end

    // |h| fraction is at most 60 per sector: 6 bits
    logic [5:0] hq;
    logic [6:0] sq;
    logic [10:0] side_h, side_s;
    hsva_divider #(.NW(14), .DW(8), .QW(6), .PW(11)) u_hdiv (
        .aclk, .en, .num(hn_reg), .den(dl_reg),
        .side_in({sel_reg, neg_reg, 1'b0, v_reg}), .quo(hq), .side_out(side_h)
    );
    hsva_divider #(.NW(15), .DW(8), .QW(7), .PW(11)) u_sdiv (
        .aclk, .en, .num(sn_reg), .den(mx_reg),
        .side_in('0), .quo(sq), .side_out(side_s)
    );
    // equalize: hue path is one stage shorter
    logic [5:0]  hq_d;
    logic [10:0] sh_d;
    always_ff @(posedge aclk) begin
        if (en) begin
            hq_d <= hq;
            sh_d <= side_h;
        end
    end

    logic signed [11:0] h, hsum;
    logic signed [8:0]  ssum, vsum;
    logic [9:0] hw;
    always_comb begin
        h = sh_d[8] ? -12'(hq_d) : 12'(hq_d);
        if (sh_d[10:9] == 2'd1) h = h + 12'sd120;
        if (sh_d[10:9] == 2'd2) h = h + 12'sd240;
        hsum = h + 12'(hue_shift) + 12'sd360;
        if (hsum >= 12'sd720) hsum = hsum - 12'sd720;
        else if (hsum >= 12'sd360) hsum = hsum - 12'sd360;
        if (hsum < 12'sd0) hsum = hsum + 12'sd360;
        hw = hsum[9:0];
        ssum = 9'(sq) + 9'(sat_shift);
        vsum = 9'(sh_d[6:0]) + 9'(val_shift);
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            hsv_reg.hue <= hw[8:0];
            hsv_reg.sat <= ssum < 0 ? 7'd0 : (ssum > 9'sd100 ? 7'd100 : ssum[6:0]);
            hsv_reg.val <= vsum < 0 ? 7'd0 : (vsum > 9'sd100 ? 7'd100 : vsum[6:0]);
        end
    end
    logic unused;
    assign unused = ^side_s;
endmodule
`default_nettype wire

FILE: src/hsva_back.sv
`default_nettype none
// Adjusted HSV to RGB, four stages.
module hsva_back
    import hsva_pkg::*;
(
    input  wire logic aclk,
    input  wire logic en,
    input  wire hsv_t hsv,
    output rgb_t      rgb_reg
);
    // stage 1: sector, fraction, products of S
    logic [2:0]  sec_reg;
    logic [13:0] sf_reg, sg_reg, sp_reg;
    logic [6:0]  v1_reg;
    logic        gray_reg;
    logic [2:0]  sec;
    logic [5:0]  fr;
    always_comb begin
        priority if (hsv.hue >= 9'd300) sec = 3'd5;
        else if (hsv.hue >= 9'd240) sec = 3'd4;
        else if (hsv.hue >= 9'd180) sec = 3'd3;
        else if (hsv.hue >= 9'd120) sec = 3'd2;
        else if (hsv.hue >= 9'd60) sec = 3'd1;
        else sec = 3'd0;
        fr  = 6'(hsv.hue - 9'(sec) * 9'd60);
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            sec_reg  <= sec;
            sf_reg   <= 14'd6000 - 14'(hsv.sat) * 14'(fr);
            sg_reg   <= 14'd6000 - 14'(hsv.sat) * 14'(6'd60 - fr);
            sp_reg   <= 14'd60 * 14'(7'd100 - hsv.sat);
            v1_reg   <= hsv.val;
            gray_reg <= hsv.sat == 7'd0;
        end
    end
    // stage 2: multiply by V (values < 600001)
    logic [19:0] nv_reg, nq_reg, nt_reg, np_reg;
    logic [2:0]  sec2_reg;
    logic        gray2_reg;
    logic [6:0]  v2_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            nv_reg    <= 20'(v1_reg) * 20'd6000;
            nq_reg    <= 20'(v1_reg) * 20'(sf_reg);
            nt_reg    <= 20'(v1_reg) * 20'(sg_reg);
            np_reg    <= 20'(v1_reg) * 20'(sp_reg);
            sec2_reg  <= sec_reg;
            gray2_reg <= gray_reg;
            v2_reg    <= v1_reg;
        end
    end
    // stage 3: select, scale by 255
    logic [19:0] cr, cg, cb;
    always_comb begin
        unique case (sec2_reg)
            3'd0: begin cr = nv_reg; cg = nt_reg; cb = np_reg; end
            3'd1: begin cr = nq_reg; cg = nv_reg; cb = np_reg; end
            3'd2: begin cr = np_reg; cg = nv_reg; cb = nt_reg; end
            3'd3: begin cr = np_reg; cg = nq_reg; cb = nv_reg; end
            3'd4: begin cr = nt_reg; cg = np_reg; cb = nv_reg; end
            default: begin cr = nv_reg; cg = np_reg; cb = nq_reg; end
        endcase
    end
    logic [27:0] sr_reg, sg2_reg, sb_reg;
    logic [14:0] gy_reg;
    logic        gray3_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            sr_reg    <= 28'(cr) * 28'd255;
            sg2_reg   <= 28'(cg) * 28'd255;
            sb_reg    <= 28'(cb) * 28'd255;
            gy_reg    <= 15'(v2_reg) * 15'd255;
            gray3_reg <= gray2_reg;
        end
    end
    // stage 4: divide by 600000 via reciprocal (x < 2^28), gray by 100
    function automatic logic [7:0] d600k(input logic [27:0] x);
        logic [63:0] p;
        logic [27:0] q;
        begin
            p = 64'(x) * 64'd469124962;  // ceil(2^48 / 600000)
            q = 28'(p >> 48);
            d600k = 8'(q);
        end
    endfunction
    always_ff @(posedge aclk) begin
        if (en) begin
            if (gray3_reg) begin
                rgb_reg.red   <= 8'((32'(gy_reg) * 32'd5243) >> 19);
                rgb_reg.green <= 8'((32'(gy_reg) * 32'd5243) >> 19);
                rgb_reg.blue  <= 8'((32'(gy_reg) * 32'd5243) >> 19);
            end else begin
                rgb_reg.red   <= d600k(sr_reg);
                rgb_reg.green <= d600k(sg2_reg);
                rgb_reg.blue  <= d600k(sb_reg);
            end
        end
    end
endmodule
`default_nettype wire
